// ----- hdl/kfe_pkg.sv -----
// ----------------------------------------------------------------------------
// kfe_pkg
// Shared constants and types of the KISS frame encoder: the KISS control
// bytes, the item descriptor passed from front to back, and the result item.
// ----------------------------------------------------------------------------
package kfe_pkg;

    localparam logic [7:0] KISS_FEND  = 8'hC0;
    localparam logic [7:0] KISS_FESC  = 8'hDB;
    localparam logic [7:0] KISS_TFEND = 8'hDC;
    localparam logic [7:0] KISS_TFESC = 8'hDD;
    localparam logic [7:0] KISS_CMD   = 8'h00;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] REG_MAX_OUTPUT_LEN = 3'd0;

    typedef struct packed {
        logic       is_end;
        logic       is_esc;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } kfe_desc_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic        frame_done;
        logic [15:0] frame_length;
        logic        overflow;
    } kfe_result_t;

endpackage

// ----- hdl/kiss_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// kiss_frame_encoder
// KISS framing with byte stuffing: opening FEND and command byte, escaped
// payload, closing FEND with the frame length, and abort on capacity.
//
//   Channel   Signals                                  Direction
//   input     in_valid/in_ready, action, frame_byte    into block
//   output    out_valid/out_ready, out_byte, ...       out of block
//   config    psel/penable/pwrite/paddr/pwdata/prdata  APB slave
//
// The back end writes one output byte per cycle unless the output stalls:
// one byte for a plain byte or end item, two for an escaped byte, and two
// more when it opens a frame; items of a dropped frame give no output byte.
// A four-entry queue lets input items be taken while the back end stalls.
// Reset clears the frame state and sets max_output_len to 1024.
// ----------------------------------------------------------------------------
module kiss_frame_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  frame_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        frame_done,
    output logic [15:0] frame_length,
    output logic        overflow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]          max_len_reg, max_len_next;
    kfe_pkg::kfe_desc_t   desc;
    kfe_pkg::kfe_desc_t   head;
    logic                 full;
    logic                 head_valid;
    logic                 pop;
    kfe_pkg::kfe_result_t result;

    assign pready   = 1'b1;
    assign in_ready = !full;
    assign prdata   = (paddr == kfe_pkg::REG_MAX_OUTPUT_LEN) ? {16'h0000, max_len_reg} : 32'h0;

    always_comb
    begin
        max_len_next = max_len_reg;
        if (psel && penable && pwrite && (paddr == kfe_pkg::REG_MAX_OUTPUT_LEN))
        begin
            max_len_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= kfe_pkg::MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    kfe_front u_front (
        .action     (action),
        .frame_byte (frame_byte),
        .desc       (desc)
    );

    kfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !full),
        .push_desc  (desc),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    kfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_len    (max_len_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign out_byte     = result.out_byte;
    assign last_of_run  = result.last_of_run;
    assign frame_done   = result.frame_done;
    assign frame_length = result.frame_length;
    assign overflow     = result.overflow;

endmodule

// ----- hdl/kfe_front.sv -----
// ----------------------------------------------------------------------------
// kfe_front
// Classifies an input item into a descriptor: end of frame, escaped byte
// pair, or plain byte, with the bytes that the back end has to write.
// ----------------------------------------------------------------------------
module kfe_front (
    input  logic              action,
    input  logic [7:0]        frame_byte,
    output kfe_pkg::kfe_desc_t desc
);

    always_comb
    begin
        desc.is_end      = 1'b0;
        desc.is_esc      = 1'b0;
        desc.first_byte  = frame_byte;
        desc.second_byte = kfe_pkg::KISS_TFEND;
        if (action == kfe_pkg::ACTION_END)
        begin
            desc.is_end     = 1'b1;
            desc.first_byte = kfe_pkg::KISS_FEND;
        end
        else if (frame_byte == kfe_pkg::KISS_FEND)
        begin
            desc.is_esc      = 1'b1;
            desc.first_byte  = kfe_pkg::KISS_FESC;
            desc.second_byte = kfe_pkg::KISS_TFEND;
        end
        else if (frame_byte == kfe_pkg::KISS_FESC)
        begin
            desc.is_esc      = 1'b1;
            desc.first_byte  = kfe_pkg::KISS_FESC;
            desc.second_byte = kfe_pkg::KISS_TFESC;
        end
    end

endmodule

// ----- hdl/kfe_queue.sv -----
// ----------------------------------------------------------------------------
// kfe_queue
// Short descriptor queue between the front and the back end.
// ----------------------------------------------------------------------------
module kfe_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kfe_pkg::kfe_desc_t push_desc,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output kfe_pkg::kfe_desc_t head
);

    kfe_pkg::kfe_desc_t             slot_reg [kfe_pkg::QUEUE_DEPTH];
    logic [kfe_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [kfe_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [kfe_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full       = (count_reg == kfe_pkg::QCNT_W'(kfe_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- hdl/kfe_back.sv -----
// ----------------------------------------------------------------------------
// kfe_back
// Byte sequencer: writes the header, the payload bytes and the closing FEND
// one byte per cycle unless the output stalls, checks every byte against the
// capacity, handles overflow and drop state, and registers the result item.
// ----------------------------------------------------------------------------
module kfe_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          max_len,
    input  logic                 head_valid,
    input  kfe_pkg::kfe_desc_t   head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kfe_pkg::kfe_result_t result
);

    localparam logic [1:0] PH_FEND   = 2'd0;
    localparam logic [1:0] PH_CMD    = 2'd1;
    localparam logic [1:0] PH_FIRST  = 2'd2;
    localparam logic [1:0] PH_SECOND = 2'd3;

    logic [1:0]           phase_reg, phase_next;
    logic                 busy_reg, busy_next;
    logic [15:0]          pos_reg, pos_next;
    logic                 header_sent_reg, header_sent_next;
    logic                 dropping_reg, dropping_next;
    logic                 out_valid_reg, out_valid_next;
    kfe_pkg::kfe_result_t out_reg, out_next;

    logic                 can_emit;
    logic [1:0]           cur_phase;
    logic [7:0]           cur_byte;
    logic                 item_last;
    kfe_pkg::kfe_result_t res;

    assign out_valid = out_valid_reg;
    assign result    = out_reg;
    assign can_emit  = !out_valid_reg || out_ready;
    assign cur_phase = busy_reg ? phase_reg : (header_sent_reg ? PH_FIRST : PH_FEND);
    assign item_last = ((cur_phase == PH_FIRST) && !head.is_esc) || (cur_phase == PH_SECOND);

    always_comb
    begin
        unique case (cur_phase)
            PH_FEND:   cur_byte = kfe_pkg::KISS_FEND;
            PH_CMD:    cur_byte = kfe_pkg::KISS_CMD;
            PH_FIRST:  cur_byte = head.first_byte;
            PH_SECOND: cur_byte = head.second_byte;
            default:   cur_byte = kfe_pkg::KISS_FEND;
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        busy_next        = busy_reg;
        pos_next         = pos_reg;
        header_sent_next = header_sent_reg;
        dropping_next    = dropping_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_next         = out_reg;
        pop              = 1'b0;
        res              = '0;
        if (head_valid)
        begin
            if (dropping_reg)
            begin
                pop = 1'b1;
                if (head.is_end)
                begin
                    pos_next         = '0;
                    header_sent_next = 1'b0;
                    dropping_next    = 1'b0;
                end
            end
            else if (can_emit)
            begin
                out_valid_next = 1'b1;
                if ((cur_phase == PH_FEND) || (cur_phase == PH_CMD))
                begin
                    header_sent_next = 1'b1;
                end
                if (pos_reg >= max_len)
                begin
                    res.overflow    = 1'b1;
                    res.last_of_run = 1'b1;
                    pop             = 1'b1;
                    busy_next       = 1'b0;
                    if (head.is_end)
                    begin
                        pos_next         = '0;
                        header_sent_next = 1'b0;
                        dropping_next    = 1'b0;
                    end
                    else
                    begin
                        dropping_next = 1'b1;
                    end
                end
                else
                begin
                    pos_next        = pos_reg + 16'd1;
                    res.out_byte    = cur_byte;
                    res.last_of_run = item_last;
                    if (item_last)
                    begin
                        pop       = 1'b1;
                        busy_next = 1'b0;
                        if (head.is_end)
                        begin
                            res.frame_done   = 1'b1;
                            res.frame_length = pos_reg + 16'd1;
                            pos_next         = '0;
                            header_sent_next = 1'b0;
                            dropping_next    = 1'b0;
                        end
                    end
                    else
                    begin
                        busy_next  = 1'b1;
                        phase_next = cur_phase + 2'd1;
                    end
                end
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FEND;
            busy_reg        <= 1'b0;
            pos_reg         <= '0;
            header_sent_reg <= 1'b0;
            dropping_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            busy_reg        <= busy_next;
            pos_reg         <= pos_next;
            header_sent_reg <= header_sent_next;
            dropping_reg    <= dropping_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.overflow |->
            out_reg.last_of_run && !out_reg.frame_done && (out_reg.out_byte == 8'h00))
        else $error("Overflow item carries data or is not the last of its run.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.frame_done |->
            out_reg.last_of_run && (out_reg.out_byte == kfe_pkg::KISS_FEND))
        else $error("Closing item is not a final FEND.");

    assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> header_sent_reg && !busy_reg)
        else $error("Drop state entered outside a started frame.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("Queue popped while empty.");
`endif

endmodule
